FILE: src/fpfa_pkg.sv
// ----------------------------------------------------------------------------
// fpfa_pkg
// Shared types and constants of the fixed-partition fit allocator: field
// widths, function, mode and status codes, and the records that run along
// the row of partition cells.
// ----------------------------------------------------------------------------
package fpfa_pkg;

    localparam int MAX_BLOCKS     = 64;
    localparam int NUM_BLOCKS_DEF = 16;

    localparam int IDX_W  = $clog2(MAX_BLOCKS);
    localparam int SIZE_W = 16;
    localparam int SUM_W  = SIZE_W + IDX_W;
    localparam int FREE_W = 20;
    localparam int FUNC_W = 2;
    localparam int MODE_W = 2;
    localparam int ACT_W  = 5;
    localparam int STAT_W = 2;
    localparam int GIDX_W = 4;
    localparam int BIDX_W = 4;
    localparam int ADDR_W = 3;
    localparam int DATA_W = 32;

    // Item functions
    localparam logic [FUNC_W-1:0] FN_LOAD  = 2'd0;
    localparam logic [FUNC_W-1:0] FN_ALLOC = 2'd1;
    localparam logic [FUNC_W-1:0] FN_CLEAR = 2'd2;

    // Placement policies; the spare code behaves as first fit
    localparam logic [MODE_W-1:0] FIT_FIRST = 2'd0;
    localparam logic [MODE_W-1:0] FIT_BEST  = 2'd1;
    localparam logic [MODE_W-1:0] FIT_WORST = 2'd2;

    // Result status
    localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
    localparam logic [STAT_W-1:0] ST_NOFIT   = 2'd1;
    localparam logic [STAT_W-1:0] ST_INVALID = 2'd2;

    // Register map, indexed by paddr[2]
    localparam logic REG_FIT_MODE = 1'b0;
    localparam logic REG_ACTIVE   = 1'b1;

    localparam logic [MODE_W-1:0] FIT_MODE_RST = FIT_FIRST;
    localparam logic [ACT_W-1:0]  ACTIVE_RST   = 5'd16;
    localparam logic [FREE_W-1:0] FREE_MAX     = '1;

    // Record handed from cell to cell during a sweep
    typedef struct packed {
        logic              valid;
        logic              found;
        logic [IDX_W-1:0]  pick;
        logic [SIZE_W-1:0] pick_size;
        logic [SUM_W-1:0]  sum;
    } tok_t;

    // Broadcast control from the sequencer to every cell
    typedef struct packed {
        logic              load_en;
        logic              clear_en;
        logic              alloc_en;
        logic [IDX_W-1:0]  ld_idx;
        logic [SIZE_W-1:0] ld_size;
        logic [IDX_W-1:0]  al_idx;
        logic              seek;
        logic [SIZE_W-1:0] req;
        logic [MODE_W-1:0] mode;
        logic [ACT_W-1:0]  active;
    } ctl_t;

endpackage

FILE: src/fixed_partition_fit_allocator_core.sv
// ----------------------------------------------------------------------------
// fixed_partition_fit_allocator_core
// Fixed-partition allocator with first, best and worst fit placement over a
// row of partition cells, with an APB-style register port.
// ----------------------------------------------------------------------------
// The block holds NUM_BLOCKS partitions, one per cell in a row. An item is a
// load (set one partition's size and free it), an allocate (grant a free
// active partition at least the requested size, chosen by fit_mode) or a
// clear (free everything). Every item gives exactly one result carrying the
// status, the granted partition, the internal fragment and the total free
// size of the active partitions after the item. The sweep record enters the
// row the cycle after intake and walks it through each cell's register; it
// is then captured, and the grant is committed as the output register is
// loaded. One item is in work at a time; s_ready returns the cycle after the
// result is loaded, so a result held by m_ready low delays the next
// acceptance by the stall. A new item may be accepted while the previous
// result still waits on m_ready.
// Registers: 0x0 fit_mode (0 first, 1 best, 2 worst, 3 as first fit),
// 0x4 active_blocks (partitions in use from index zero; values above
// NUM_BLOCKS act as NUM_BLOCKS). Write registers only while idle.
// ----------------------------------------------------------------------------
module fixed_partition_fit_allocator_core import fpfa_pkg::*; #(
    parameter int NUM_BLOCKS = NUM_BLOCKS_DEF
) (
    input  logic              aclk,
    input  logic              aresetn,
    // configuration port
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,
    // input items
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [FUNC_W-1:0] s_func,
    input  logic [BIDX_W-1:0] s_block_index,
    input  logic [SIZE_W-1:0] s_size,
    // result items
    output logic              m_valid,
    input  logic              m_ready,
    output logic [STAT_W-1:0] m_status,
    output logic [GIDX_W-1:0] m_granted_index,
    output logic [SIZE_W-1:0] m_fragment,
    output logic [FREE_W-1:0] m_free_total
);

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_SWEEP = 3'b010,
        ST_DRAIN = 3'b100
    } state_t;

    state_t            state_reg, state_next;
    logic [MODE_W-1:0] fit_mode_reg;
    logic [ACT_W-1:0]  active_reg;
    logic              launch_reg;
    logic [FUNC_W-1:0] op_func_reg;
    logic [SIZE_W-1:0] op_size_reg;
    logic              op_bad_reg;
    tok_t              fin_reg;
    logic              m_valid_reg;
    logic [STAT_W-1:0] m_status_reg;
    logic [GIDX_W-1:0] m_gidx_reg;
    logic [SIZE_W-1:0] m_frag_reg;
    logic [FREE_W-1:0] m_free_reg;

    logic              cfg_wr;
    logic              s_fire;
    logic              idx_ok;
    logic              in_bad;
    logic              out_free;
    logic              drain_fire;
    ctl_t              ctl;
    tok_t              tok_w [NUM_BLOCKS+1];
    logic [NUM_BLOCKS:0] tok_vld;

    logic [STAT_W-1:0] res_status;
    logic [GIDX_W-1:0] res_gidx;
    logic [SIZE_W-1:0] res_frag;
    logic [SUM_W-1:0]  res_diff;
    logic [FREE_W-1:0] res_free;

    // ---------------------------------------------------------------------
    // Register port: zero wait states, decode on paddr[2]
    // ---------------------------------------------------------------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_comb begin
        unique case (paddr[2])
            REG_FIT_MODE: prdata = DATA_W'(fit_mode_reg);
            REG_ACTIVE:   prdata = DATA_W'(active_reg);
            default:      prdata = '0;
        endcase
    end

    // ---------------------------------------------------------------------
    // Item intake: classify on arrival, apply loads and clears at once
    // ---------------------------------------------------------------------
    assign s_ready = (state_reg == ST_IDLE);
    assign s_fire  = s_valid && s_ready;
    assign idx_ok  = (IDX_W+1)'(s_block_index) < (IDX_W+1)'(NUM_BLOCKS);

    always_comb begin
        unique case (s_func)
            FN_LOAD:  in_bad = !idx_ok;
            FN_ALLOC: in_bad = (s_size == '0);
            FN_CLEAR: in_bad = 1'b0;
            default:  in_bad = 1'b1;
        endcase
    end

    assign out_free   = !m_valid_reg || m_ready;
    assign drain_fire = (state_reg == ST_DRAIN) && out_free;

    always_comb begin
        ctl.load_en  = s_fire && (s_func == FN_LOAD) && idx_ok;
        ctl.clear_en = s_fire && (s_func == FN_CLEAR);
        ctl.alloc_en = drain_fire && fin_reg.found;
        ctl.ld_idx   = IDX_W'(s_block_index);
        ctl.ld_size  = s_size;
        ctl.al_idx   = fin_reg.pick;
        ctl.seek     = (op_func_reg == FN_ALLOC) && !op_bad_reg;
        ctl.req      = op_size_reg;
        ctl.mode     = fit_mode_reg;
        ctl.active   = active_reg;
    end

    // ---------------------------------------------------------------------
    // Row of cells: the sweep record enters cell 0 the cycle after intake,
    // so it sees the table with the load or clear already applied
    // ---------------------------------------------------------------------
    always_comb begin
        tok_w[0]       = '0;
        tok_w[0].valid = launch_reg;
    end

    for (genvar k = 0; k < NUM_BLOCKS; k++) begin : g_cell
        fpfa_cell #(
            .CELL_IDX (k)
        ) u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .ctl     (ctl),
            .tok_in  (tok_w[k]),
            .tok_out (tok_w[k+1])
        );
    end

    for (genvar k = 0; k <= NUM_BLOCKS; k++) begin : g_vld
        assign tok_vld[k] = tok_w[k].valid;
    end

    // ---------------------------------------------------------------------
    // Result: the sweep sum counts the granted partition as still free, so
    // drop its size before saturating
    // ---------------------------------------------------------------------
    always_comb begin
        if (op_bad_reg) begin
            res_status = ST_INVALID;
        end else if ((op_func_reg == FN_ALLOC) && !fin_reg.found) begin
            res_status = ST_NOFIT;
        end else begin
            res_status = ST_OK;
        end
        res_gidx = fin_reg.found ? fin_reg.pick[GIDX_W-1:0] : '0;
        res_frag = fin_reg.found ? (fin_reg.pick_size - op_size_reg) : '0;
        res_diff = fin_reg.sum - (fin_reg.found ? SUM_W'(fin_reg.pick_size) : SUM_W'(0));
        res_free = (res_diff > SUM_W'(FREE_MAX)) ? FREE_MAX : res_diff[FREE_W-1:0];
    end

    // ---------------------------------------------------------------------
    // Sequencer
    // ---------------------------------------------------------------------
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:  if (s_fire) begin
                state_next = ST_SWEEP;
            end
            ST_SWEEP: if (tok_w[NUM_BLOCKS].valid) begin
                state_next = ST_DRAIN;
            end
            ST_DRAIN: if (out_free) begin
                state_next = ST_IDLE;
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            launch_reg   <= 1'b0;
            m_valid_reg  <= 1'b0;
            fit_mode_reg <= FIT_MODE_RST;
            active_reg   <= ACTIVE_RST;
        end else begin
            state_reg  <= state_next;
            launch_reg <= s_fire;
            if (drain_fire) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (cfg_wr) begin
                unique case (paddr[2])
                    REG_FIT_MODE: fit_mode_reg <= pwdata[MODE_W-1:0];
                    REG_ACTIVE:   active_reg   <= pwdata[ACT_W-1:0];
                    default:      ;
                endcase
            end
        end
    end

    // Payload: hold the item's operands, capture the finished sweep, load
    // the output register when it frees up
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            op_func_reg <= s_func;
            op_size_reg <= s_size;
            op_bad_reg  <= in_bad;
        end
        if ((state_reg == ST_SWEEP) && tok_w[NUM_BLOCKS].valid) begin
            fin_reg <= tok_w[NUM_BLOCKS];
        end
        if (drain_fire) begin
            m_status_reg <= res_status;
            m_gidx_reg   <= res_gidx;
            m_frag_reg   <= res_frag;
            m_free_reg   <= res_free;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_status        = m_status_reg;
    assign m_granted_index = m_gidx_reg;
    assign m_fragment      = m_frag_reg;
    assign m_free_total    = m_free_reg;

    // ---------------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------------
    a_one_sweep: assert property (@(posedge aclk) disable iff (!aresetn)
        $countones(tok_vld) <= 1)
        else $error("more than one sweep record in the row");

    a_exit_in_sweep: assert property (@(posedge aclk) disable iff (!aresetn)
        tok_w[NUM_BLOCKS].valid |-> (state_reg == ST_SWEEP))
        else $error("sweep record left the row outside the sweep state");

    a_grant_fits: assert property (@(posedge aclk) disable iff (!aresetn)
        ((state_reg == ST_DRAIN) && fin_reg.found)
        |-> (((IDX_W+1)'(fin_reg.pick) < (IDX_W+1)'(NUM_BLOCKS))
             && (fin_reg.pick_size >= op_size_reg)))
        else $error("granted partition out of range or too small");

    a_result_from_drain: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == ST_DRAIN))
        else $error("result offered without a finished sweep");

endmodule

FILE: src/fpfa_cell.sv
// ----------------------------------------------------------------------------
// fpfa_cell
// One partition of the table: holds its size and used mark, and updates the
// passing sweep record with its fit candidate and its share of free space.
// ----------------------------------------------------------------------------
module fpfa_cell import fpfa_pkg::*; #(
    parameter int CELL_IDX = 0
) (
    input  logic aclk,
    input  logic aresetn,
    input  ctl_t ctl,
    input  tok_t tok_in,
    output tok_t tok_out
);

    localparam logic [IDX_W-1:0] MY_IDX  = IDX_W'(CELL_IDX);
    localparam logic [IDX_W:0]   MY_CMP  = (IDX_W+1)'(CELL_IDX);

    logic [SIZE_W-1:0] size_reg;
    logic              used_reg;
    tok_t              tok_reg;
    tok_t              tok_next;
    logic              active;
    logic              free_here;
    logic              eligible;
    logic              better;
    logic              take;

    always_comb begin
        active    = (IDX_W+1)'(ctl.active) > MY_CMP;
        free_here = active && !used_reg;
        eligible  = ctl.seek && free_here && (size_reg >= ctl.req);
        better    = !tok_in.found
                    || ((ctl.mode == FIT_BEST)  && (size_reg < tok_in.pick_size))
                    || ((ctl.mode == FIT_WORST) && (size_reg > tok_in.pick_size));
        take      = eligible && better;

        tok_next.valid     = tok_in.valid;
        tok_next.found     = tok_in.found || take;
        tok_next.pick      = take ? MY_IDX : tok_in.pick;
        tok_next.pick_size = take ? size_reg : tok_in.pick_size;
        tok_next.sum       = tok_in.sum + (free_here ? SUM_W'(size_reg) : SUM_W'(0));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            size_reg <= '0;
            used_reg <= 1'b0;
            tok_reg  <= '0;
        end else begin
            tok_reg <= tok_next;
            if (ctl.clear_en) begin
                used_reg <= 1'b0;
            end
            if (ctl.load_en && (ctl.ld_idx == MY_IDX)) begin
                size_reg <= ctl.ld_size;
                used_reg <= 1'b0;
            end
            if (ctl.alloc_en && (ctl.al_idx == MY_IDX)) begin
                used_reg <= 1'b1;
            end
        end
    end

    assign tok_out = tok_reg;

endmodule
